@@ sv/bced_pkg.sv @@
package bced_pkg;

  localparam int TickW      = 32;
  localparam int CdW        = 16;
  localparam int PhW        = 3;
  localparam int CodeW      = 3;
  localparam int MaskW      = 4;
  localparam int KeyIdW     = 2;
  localparam int PeriodW    = 8;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 16;
  localparam int MaxResults = 8;
  localparam int CntW       = 3;

  localparam logic [PhW-1:0] PH_IDLE           = 3'd0;
  localparam logic [PhW-1:0] PH_WAIT_HOLD      = 3'd1;
  localparam logic [PhW-1:0] PH_WAIT_DOUBLE    = 3'd2;
  localparam logic [PhW-1:0] PH_WAIT_DOUBLE_UP = 3'd3;
  localparam logic [PhW-1:0] PH_LONG_REPEAT    = 3'd4;

  localparam logic [CodeW-1:0] EV_DOWN   = 3'd0;
  localparam logic [CodeW-1:0] EV_UP     = 3'd1;
  localparam logic [CodeW-1:0] EV_SINGLE = 3'd2;
  localparam logic [CodeW-1:0] EV_DOUBLE = 3'd3;
  localparam logic [CodeW-1:0] EV_LONG   = 3'd4;
  localparam logic [CodeW-1:0] EV_REPEAT = 3'd5;

  localparam logic [CfgIdxW-1:0] REG_ACTIVE_HIGH = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PERIOD      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LONG        = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_GAP         = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_REPEAT      = 3'd4;

  // edge event (down/up) and phase event of one key at one sample
  typedef struct packed {
    logic             a_vld;
    logic [CodeW-1:0] a_code;
    logic             b_vld;
    logic [CodeW-1:0] b_code;
    logic [TickW-1:0] dur;
  } key_ev_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ sv/bced_front.sv @@
module bced_front #(
  parameter int NUM_KEYS = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [bced_pkg::CfgIdxW-1:0]           cfg_index,
  input  logic [bced_pkg::CfgDataW-1:0]          cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [bced_pkg::MaskW-1:0]             in_raw_levels,
  input  bced_pkg::q_stat_t                      q_stat,
  output logic                                   push,
  output bced_pkg::key_ev_t [NUM_KEYS-1:0]       push_ev,
  output logic [bced_pkg::MaskW-1:0]             push_mask
);

  localparam int KW = NUM_KEYS + bced_pkg::MaskW;

  logic [bced_pkg::MaskW-1:0]   ah_r;
  logic [bced_pkg::PeriodW-1:0] period_r;
  logic [bced_pkg::CdW-1:0]     long_r;
  logic [bced_pkg::CdW-1:0]     gap_r;
  logic [bced_pkg::CdW-1:0]     rep_r;

  logic [bced_pkg::PeriodW-1:0] div_r, div_nxt;
  logic [bced_pkg::TickW-1:0]   tick_r, tick_nxt;
  logic [NUM_KEYS-1:0]          last_r, last_nxt;
  logic [NUM_KEYS-1:0][bced_pkg::PhW-1:0]   ph_r, ph_nxt;
  logic [NUM_KEYS-1:0][bced_pkg::CdW-1:0]   cd_r, cd_nxt;
  logic [NUM_KEYS-1:0][bced_pkg::TickW-1:0] pt_r, pt_nxt;

  logic [bced_pkg::PeriodW-1:0] div_inc;
  logic                         smp;
  logic                         accept;
  logic                         any_ev;
  logic [KW-1:0]                raw_x;
  logic [KW-1:0]                ah_x;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && any_ev;

  always_comb begin
    logic                       p;
    logic                       was;
    logic                       down;
    logic                       up;
    logic [bced_pkg::CdW-1:0]   cd_dec;
    logic [bced_pkg::TickW-1:0] dur;
    tick_nxt = tick_r + 1'b1;
    div_inc  = div_r + 1'b1;
    smp      = div_inc >= period_r;
    div_nxt  = smp ? '0 : div_inc;
    raw_x    = KW'(in_raw_levels);
    ah_x     = KW'(ah_r);
    for (int j = 0; j < bced_pkg::MaskW; j++) begin
      push_mask[j] = (j < NUM_KEYS) && (in_raw_levels[j] == ah_r[j]);
    end
    last_nxt = last_r;
    any_ev   = 1'b0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      cd_dec     = (cd_r[k] != '0) ? cd_r[k] - 1'b1 : cd_r[k];
      cd_nxt[k]  = cd_dec;
      ph_nxt[k]  = ph_r[k];
      pt_nxt[k]  = pt_r[k];
      push_ev[k] = '0;
      p    = raw_x[k] == ah_x[k];
      was  = last_r[k];
      down = p && !was;
      up   = !p && was;
      dur  = down ? '0 : tick_nxt - pt_r[k];
      if (smp) begin
        last_nxt[k]       = p;
        push_ev[k].a_vld  = down || up;
        push_ev[k].a_code = down ? bced_pkg::EV_DOWN : bced_pkg::EV_UP;
        push_ev[k].dur    = dur;
        if (down) begin
          pt_nxt[k] = tick_nxt;
        end
        unique case (ph_r[k])
          bced_pkg::PH_IDLE: begin
            if (p) begin
              cd_nxt[k] = long_r;
              ph_nxt[k] = bced_pkg::PH_WAIT_HOLD;
            end
          end
          bced_pkg::PH_WAIT_HOLD: begin
            if (!p) begin
              cd_nxt[k] = gap_r;
              ph_nxt[k] = bced_pkg::PH_WAIT_DOUBLE;
            end else if (cd_dec == '0) begin
              push_ev[k].b_vld  = 1'b1;
              push_ev[k].b_code = bced_pkg::EV_LONG;
              cd_nxt[k] = rep_r;
              ph_nxt[k] = bced_pkg::PH_LONG_REPEAT;
            end
          end
          bced_pkg::PH_WAIT_DOUBLE: begin
            if (p) begin
              push_ev[k].b_vld  = 1'b1;
              push_ev[k].b_code = bced_pkg::EV_DOUBLE;
              ph_nxt[k] = bced_pkg::PH_WAIT_DOUBLE_UP;
            end else if (cd_dec == '0) begin
              push_ev[k].b_vld  = 1'b1;
              push_ev[k].b_code = bced_pkg::EV_SINGLE;
              ph_nxt[k] = bced_pkg::PH_IDLE;
            end
          end
          bced_pkg::PH_WAIT_DOUBLE_UP: begin
            if (!p) begin
              ph_nxt[k] = bced_pkg::PH_IDLE;
            end
          end
          bced_pkg::PH_LONG_REPEAT: begin
            if (!p) begin
              ph_nxt[k] = bced_pkg::PH_IDLE;
            end else if (cd_dec == '0) begin
              push_ev[k].b_vld  = 1'b1;
              push_ev[k].b_code = bced_pkg::EV_REPEAT;
              cd_nxt[k] = rep_r;
            end
          end
          default: begin
            ph_nxt[k] = bced_pkg::PH_IDLE;
          end
        endcase
      end
      any_ev = any_ev || push_ev[k].a_vld || push_ev[k].b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ah_r     <= '0;
      period_r <= bced_pkg::PeriodW'(20);
      long_r   <= bced_pkg::CdW'(1000);
      gap_r    <= bced_pkg::CdW'(200);
      rep_r    <= bced_pkg::CdW'(100);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bced_pkg::REG_ACTIVE_HIGH: ah_r     <= cfg_wdata[bced_pkg::MaskW-1:0];
        bced_pkg::REG_PERIOD:      period_r <= cfg_wdata[bced_pkg::PeriodW-1:0];
        bced_pkg::REG_LONG:        long_r   <= cfg_wdata;
        bced_pkg::REG_GAP:         gap_r    <= cfg_wdata;
        bced_pkg::REG_REPEAT:      rep_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r  <= '0;
      tick_r <= '0;
      last_r <= '0;
      ph_r   <= '0;
      cd_r   <= '0;
      pt_r   <= '0;
    end else if (accept) begin
      div_r  <= div_nxt;
      tick_r <= tick_nxt;
      last_r <= last_nxt;
      ph_r   <= ph_nxt;
      cd_r   <= cd_nxt;
      pt_r   <= pt_nxt;
    end
  end

endmodule

@@ sv/bced_queue.sv @@
module bced_queue #(
  parameter int NUM_KEYS = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  input  bced_pkg::key_ev_t [NUM_KEYS-1:0] push_ev,
  input  logic [bced_pkg::MaskW-1:0]       push_mask,
  input  logic                             pop,
  output bced_pkg::q_stat_t                q_stat,
  output bced_pkg::key_ev_t [NUM_KEYS-1:0] head_ev,
  output logic [bced_pkg::MaskW-1:0]       head_mask
);

  localparam int Depth = 2;

  bced_pkg::key_ev_t [Depth-1:0][NUM_KEYS-1:0] ev_mem_r;
  logic [Depth-1:0][bced_pkg::MaskW-1:0]       mask_mem_r;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign q_stat.full  = cnt_r == 2'(Depth);
  assign q_stat.empty = cnt_r == 2'd0;
  assign do_pop       = pop && !q_stat.empty;
  assign head_ev      = ev_mem_r[rd_ptr_r];
  assign head_mask    = mask_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ev_mem_r[wr_ptr_r]   <= push_ev;
      mask_mem_r[wr_ptr_r] <= push_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ sv/bced_back.sv @@
module bced_back #(
  parameter int NUM_KEYS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bced_pkg::q_stat_t                 q_stat,
  input  bced_pkg::key_ev_t [NUM_KEYS-1:0]  head_ev,
  input  logic [bced_pkg::MaskW-1:0]        head_mask,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bced_pkg::KeyIdW-1:0]       out_key_id,
  output logic [bced_pkg::CodeW-1:0]        out_event_code,
  output logic [bced_pkg::TickW-1:0]        out_held_ticks,
  output logic [bced_pkg::MaskW-1:0]        out_pressed_mask,
  output logic                              out_last_of_tick
);

  localparam int SlotN = 2 * NUM_KEYS;

  logic [SlotN-1:0]                 pend_r, pend_nxt;
  logic [bced_pkg::CntW-1:0]        cnt_r, cnt_nxt;
  bced_pkg::key_ev_t [NUM_KEYS-1:0] ev_r;
  logic [bced_pkg::MaskW-1:0]       mask_r;
  logic                             out_valid_r, out_valid_nxt;
  logic [bced_pkg::KeyIdW-1:0]      key_r;
  logic [bced_pkg::CodeW-1:0]       code_r;
  logic [bced_pkg::TickW-1:0]       dur_r;
  logic [bced_pkg::MaskW-1:0]       omask_r;
  logic                             last_r;

  logic [SlotN-1:0]                 low;
  logic [SlotN-1:0]                 rest;
  logic [SlotN-1:0]                 head_pend;
  logic [bced_pkg::KeyIdW-1:0]      sel_key;
  logic [bced_pkg::CodeW-1:0]       sel_code;
  logic [bced_pkg::TickW-1:0]       sel_dur;
  logic                             emit;
  logic                             last;

  always_comb begin
    low      = pend_r & (~pend_r + 1'b1);
    rest     = pend_r & ~low;
    sel_key  = '0;
    sel_code = bced_pkg::EV_DOWN;
    sel_dur  = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      head_pend[2*k]   = head_ev[k].a_vld;
      head_pend[2*k+1] = head_ev[k].b_vld;
      if (low[2*k]) begin
        sel_key  = bced_pkg::KeyIdW'(k);
        sel_code = ev_r[k].a_code;
        sel_dur  = ev_r[k].dur;
      end
      if (low[2*k+1]) begin
        sel_key  = bced_pkg::KeyIdW'(k);
        sel_code = ev_r[k].b_code;
        sel_dur  = ev_r[k].dur;
      end
    end
    if (sel_code != bced_pkg::EV_UP && sel_code != bced_pkg::EV_LONG &&
        sel_code != bced_pkg::EV_REPEAT) begin
      sel_dur = '0;
    end
    emit = (pend_r != '0) && (!out_valid_r || !out_stall);
    last = (rest == '0) || (cnt_r == bced_pkg::CntW'(bced_pkg::MaxResults - 1));
    pop  = ((pend_r == '0) || (emit && last)) && !q_stat.empty;
    priority if (pop) begin
      pend_nxt = head_pend;
      cnt_nxt  = '0;
    end else if (emit) begin
      pend_nxt = last ? '0 : rest;
      cnt_nxt  = last ? '0 : cnt_r + 1'b1;
    end else begin
      pend_nxt = pend_r;
      cnt_nxt  = cnt_r;
    end
    out_valid_nxt = emit || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ev_r   <= head_ev;
      mask_r <= head_mask;
    end
    if (emit) begin
      key_r   <= sel_key;
      code_r  <= sel_code;
      dur_r   <= sel_dur;
      omask_r <= mask_r;
      last_r  <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_key_id       = key_r;
  assign out_event_code   = code_r;
  assign out_held_ticks   = dur_r;
  assign out_pressed_mask = omask_r;
  assign out_last_of_tick = last_r;

endmodule

@@ sv/button_click_event_detector_core.sv @@
// key event detector: one input item per timer tick carrying the raw pin levels
// (bit i for key i); every sample period the keys are sampled and down, up, single,
// double, long and repeat events come out as result items, up to eight per tick,
// the final one of a tick flagged by out_last_of_tick.
// configuration: cfg_we with cfg_index / cfg_wdata writes one register per cycle;
// the user must write only while no tick is in flight; the block does not enforce it.
// throughput: one tick item per cycle while the two-entry tick queue has room;
// results leave one per cycle from the output register while out_stall is low, and a
// tick's events, at most 8, keep the back end busy until its last event is emitted.
// a result passes from the tick queue through the back end's event register into the output register.
// in_stall rises only when the tick queue is full.
// when out_stall is high the output register holds its item and the back end
// waits; the front keeps taking ticks until the queue fills.
// reset: synchronous on rst_n low; registers return to their defaults
// (period 20, long 1000, gap 200, repeat 100, active-low keys), all keys idle.
module button_click_event_detector_core #(
  parameter int NUM_KEYS = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bced_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [bced_pkg::CfgDataW-1:0]    cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [bced_pkg::MaskW-1:0]       in_raw_levels,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bced_pkg::KeyIdW-1:0]      out_key_id,
  output logic [bced_pkg::CodeW-1:0]       out_event_code,
  output logic [bced_pkg::TickW-1:0]       out_held_ticks,
  output logic [bced_pkg::MaskW-1:0]       out_pressed_mask,
  output logic                             out_last_of_tick
);

  bced_pkg::q_stat_t                q_stat;
  logic                             push;
  bced_pkg::key_ev_t [NUM_KEYS-1:0] push_ev;
  logic [bced_pkg::MaskW-1:0]       push_mask;
  logic                             pop;
  bced_pkg::key_ev_t [NUM_KEYS-1:0] head_ev;
  logic [bced_pkg::MaskW-1:0]       head_mask;

  bced_front #(.NUM_KEYS(NUM_KEYS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_raw_levels (in_raw_levels),
    .q_stat        (q_stat),
    .push          (push),
    .push_ev       (push_ev),
    .push_mask     (push_mask)
  );

  bced_queue #(.NUM_KEYS(NUM_KEYS)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_ev   (push_ev),
    .push_mask (push_mask),
    .pop       (pop),
    .q_stat    (q_stat),
    .head_ev   (head_ev),
    .head_mask (head_mask)
  );

  bced_back #(.NUM_KEYS(NUM_KEYS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .head_ev          (head_ev),
    .head_mask        (head_mask),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_key_id       (out_key_id),
    .out_event_code   (out_event_code),
    .out_held_ticks   (out_held_ticks),
    .out_pressed_mask (out_pressed_mask),
    .out_last_of_tick (out_last_of_tick)
  );

  // down, single and double carry no duration
  a_zero_dur: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_code == bced_pkg::EV_DOWN ||
                  out_event_code == bced_pkg::EV_SINGLE ||
                  out_event_code == bced_pkg::EV_DOUBLE) |-> out_held_ticks == '0)
    else $error("nonzero duration on down/single/double");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_code <= bced_pkg::EV_REPEAT)
    else $error("event code out of range");

  // edge events agree with the reported pressed state
  a_down_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && NUM_KEYS <= bced_pkg::MaskW && out_event_code == bced_pkg::EV_DOWN
      |-> out_pressed_mask[out_key_id])
    else $error("down event on unpressed key");

  a_up_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && NUM_KEYS <= bced_pkg::MaskW && out_event_code == bced_pkg::EV_UP
      |-> !out_pressed_mask[out_key_id])
    else $error("up event on pressed key");

endmodule
